[src/etc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etc_pkg
// Shared types and constants of the edge trigger and capture engine.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam int VAL_W     = 10;  // sample, level and count fields
    localparam int IDX_W     = 9;   // read_index and write_index fields
    localparam int LAYER_W   = 3;   // read_layer field
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int OUTQ_DEPTH = 3;

    localparam int BUFFER_DEPTH_DEF   = 512;
    localparam int HISTORY_LAYERS_DEF = 8;
    localparam int SAMPLE_BITS_DEF    = 10;

    localparam logic [VAL_W-1:0] LEVEL_RST = VAL_W'(512);
    localparam logic [VAL_W-1:0] HYST_RST  = VAL_W'(20);
    localparam logic [VAL_W-1:0] POST_RST  = VAL_W'(384);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [2:0] {
        REG_TRIGGER_LEVEL  = 3'd0,
        REG_EDGE_RISING    = 3'd1,
        REG_HYSTERESIS     = 3'd2,
        REG_AUTO_ARM       = 3'd3,
        REG_CH1_ENABLE     = 3'd4,
        REG_CH2_ENABLE     = 3'd5,
        REG_PERSIST_ENABLE = 3'd6,
        REG_POST_COUNT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [VAL_W-1:0] trigger_level;
        logic             edge_rising;
        logic [VAL_W-1:0] hysteresis;
        logic             auto_arm;
        logic             ch1_enable;
        logic             ch2_enable;
        logic             persist_enable;
        logic [VAL_W-1:0] post_count;
    } t_cfg;

    typedef struct packed {
        logic fired;
        logic done;
        logic push;
        logic armed_now;   // armed after a sample item
        logic armed_cur;   // armed before the item, kept by read items
    } t_trig;

    typedef struct packed {
        logic             triggered;
        logic             capture_done;
        logic [IDX_W-1:0] write_index;
        logic [VAL_W-1:0] ch1_value;
        logic [VAL_W-1:0] ch2_value;
        logic [VAL_W-1:0] persist_value;
        logic             armed_now;
    } t_result;

endpackage
`default_nettype wire

[src/etc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/etc_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etc_regs
// APB configuration registers of the trigger engine.
// ----------------------------------------------------------------------------
module etc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [etc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [etc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [etc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output etc_pkg::t_cfg                      o_cfg
);
    import etc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_level  <= LEVEL_RST;
            r_cfg.edge_rising    <= 1'b1;
            r_cfg.hysteresis     <= HYST_RST;
            r_cfg.auto_arm       <= 1'b1;
            r_cfg.ch1_enable     <= 1'b1;
            r_cfg.ch2_enable     <= 1'b0;
            r_cfg.persist_enable <= 1'b0;
            r_cfg.post_count     <= POST_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TRIGGER_LEVEL:  r_cfg.trigger_level  <= pwdata[VAL_W-1:0];
                REG_EDGE_RISING:    r_cfg.edge_rising    <= pwdata[0];
                REG_HYSTERESIS:     r_cfg.hysteresis     <= pwdata[VAL_W-1:0];
                REG_AUTO_ARM:       r_cfg.auto_arm       <= pwdata[0];
                REG_CH1_ENABLE:     r_cfg.ch1_enable     <= pwdata[0];
                REG_CH2_ENABLE:     r_cfg.ch2_enable     <= pwdata[0];
                REG_PERSIST_ENABLE: r_cfg.persist_enable <= pwdata[0];
                REG_POST_COUNT:     r_cfg.post_count     <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_TRIGGER_LEVEL:  prdata = PDATA_W'(r_cfg.trigger_level);
            REG_EDGE_RISING:    prdata = PDATA_W'(r_cfg.edge_rising);
            REG_HYSTERESIS:     prdata = PDATA_W'(r_cfg.hysteresis);
            REG_AUTO_ARM:       prdata = PDATA_W'(r_cfg.auto_arm);
            REG_CH1_ENABLE:     prdata = PDATA_W'(r_cfg.ch1_enable);
            REG_CH2_ENABLE:     prdata = PDATA_W'(r_cfg.ch2_enable);
            REG_PERSIST_ENABLE: prdata = PDATA_W'(r_cfg.persist_enable);
            REG_POST_COUNT:     prdata = PDATA_W'(r_cfg.post_count);
        endcase
    end

endmodule
`default_nettype wire

[src/etc_trig.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etc_trig
// Trigger state: arming with hysteresis, post-trigger count, write pointer
// and buffer fill level.
// ----------------------------------------------------------------------------
module etc_trig #(
    parameter int BUFFER_DEPTH = etc_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  etc_pkg::t_cfg                        i_cfg,
    input  wire logic                            i_tick,
    input  wire logic [etc_pkg::VAL_W-1:0]       i_trig_sample,
    output etc_pkg::t_trig                       o_trig,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_widx,
    output logic      [$clog2(BUFFER_DEPTH):0]   o_fill
);
    import etc_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW:0]      r_fill, n_fill;
    logic             r_armed, n_armed;
    logic             r_post_phase, n_post_phase;
    logic [VAL_W-1:0] r_post_left, n_post_left;
    logic             r_capture_start, n_capture_start;

    logic [AW-1:0]    ptr;
    logic             arm0;
    logic             fired;
    logic             rearm;
    logic             done;
    logic [VAL_W-1:0] left;
    logic [VAL_W:0]   band_hi;

    always_comb begin
        ptr     = r_capture_start ? '0 : r_wr_ptr;
        arm0    = r_armed || (r_capture_start && i_cfg.auto_arm);
        band_hi = {1'b0, i_cfg.trigger_level} + {1'b0, i_cfg.hysteresis};
        fired   = 1'b0;
        rearm   = 1'b0;
        done    = 1'b0;
        left    = (r_post_left != '0) ? r_post_left - 1'b1 : r_post_left;

        if (!r_post_phase) begin
            if (arm0) begin
                fired = i_cfg.edge_rising ? (i_trig_sample >= i_cfg.trigger_level)
                                          : (i_trig_sample <= i_cfg.trigger_level);
            end else if (i_cfg.edge_rising) begin
                rearm = (i_cfg.trigger_level >= i_cfg.hysteresis) &&
                        (i_trig_sample < i_cfg.trigger_level - i_cfg.hysteresis);
            end else begin
                rearm = {1'b0, i_trig_sample} > band_hi;
            end
        end else begin
            done = (left == '0);
        end

        n_wr_ptr        = (ptr == AW'(BUFFER_DEPTH - 1)) ? '0 : ptr + 1'b1;
        n_fill          = ((AW + 1)'(ptr) == r_fill && r_fill != (AW + 1)'(BUFFER_DEPTH))
                          ? r_fill + 1'b1 : r_fill;
        n_armed         = (arm0 || rearm) && !fired;
        n_post_phase    = r_post_phase ? !done : fired;
        n_post_left     = r_post_phase ? left
                        : (i_cfg.post_count != '0 ? i_cfg.post_count : VAL_W'(1));
        n_capture_start = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr        <= '0;
            r_fill          <= '0;
            r_armed         <= 1'b0;
            r_post_phase    <= 1'b0;
            r_post_left     <= '0;
            r_capture_start <= 1'b1;
        end else if (i_tick) begin
            r_wr_ptr        <= n_wr_ptr;
            r_fill          <= n_fill;
            r_armed         <= n_armed;
            r_post_phase    <= n_post_phase;
            r_post_left     <= n_post_left;
            r_capture_start <= n_capture_start;
        end
    end

    assign o_trig.fired     = fired;
    assign o_trig.done      = done;
    assign o_trig.push      = !r_post_phase && i_cfg.persist_enable;
    assign o_trig.armed_now = n_armed;
    assign o_trig.armed_cur = r_armed;
    assign o_widx           = ptr;
    assign o_fill           = r_fill;

endmodule
`default_nettype wire

[src/etc_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etc_outq
// Small result queue that decouples the memory pipeline from the receiver.
// ----------------------------------------------------------------------------
module etc_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  etc_pkg::t_result         i_data,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output etc_pkg::t_result         o_data,
    output logic [1:0]               o_count
);
    import etc_pkg::*;

    t_result    r_q [OUTQ_DEPTH];
    logic [1:0] r_wr, r_rd, r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == 2'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == 2'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd];
    assign o_count = r_count;

endmodule
`default_nettype wire

[src/edge_trigger_capture_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edge_trigger_capture_top
// Oscilloscope edge trigger with hysteresis, capture buffer and persistence.
// ----------------------------------------------------------------------------
// Input items (i_valid/o_stall) are sample ticks or reads of stored entries;
// each gives one result item (o_valid/i_stall). Registers sit on an APB port.
// One item is taken per clock while o_stall is low. A result passes through
// the synchronous read of the sample and persistence memories, then through
// the result queue.
// A persistence push reads the row of all history layers at the write index,
// shifts it and writes it back the cycle after; a bypass register covers a
// read of the row written in the cycle before.
// Entries never written since reset read as zero: a fill level tracks the
// written part of the buffer, which always grows from index 0.
// Reset clears the trigger state and the queue; no clearing pass is needed.
// When the receiver stalls, up to three results wait in the queue, and
// o_stall rises once the queue and the memory stage together hold three.
// ----------------------------------------------------------------------------
module edge_trigger_capture_top #(
    parameter int BUFFER_DEPTH   = etc_pkg::BUFFER_DEPTH_DEF,
    parameter int HISTORY_LAYERS = etc_pkg::HISTORY_LAYERS_DEF,
    parameter int SAMPLE_BITS    = etc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [etc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [etc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [etc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_req_type,
    input  wire logic [etc_pkg::VAL_W-1:0]     i_trig_sample,
    input  wire logic [etc_pkg::VAL_W-1:0]     i_ch1_sample,
    input  wire logic [etc_pkg::VAL_W-1:0]     i_ch2_sample,
    input  wire logic [etc_pkg::IDX_W-1:0]     i_read_index,
    input  wire logic [etc_pkg::LAYER_W-1:0]   i_read_layer,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_triggered,
    output logic                               o_capture_done,
    output logic      [etc_pkg::IDX_W-1:0]     o_write_index,
    output logic      [etc_pkg::VAL_W-1:0]     o_ch1_value,
    output logic      [etc_pkg::VAL_W-1:0]     o_ch2_value,
    output logic      [etc_pkg::VAL_W-1:0]     o_persist_value,
    output logic                               o_armed_now
);
    import etc_pkg::*;

    localparam int AW        = $clog2(BUFFER_DEPTH);
    localparam int SW        = SAMPLE_BITS;
    localparam int LW        = (HISTORY_LAYERS > 1) ? $clog2(HISTORY_LAYERS) : 1;
    localparam int RIDX_QMAX = ((1 << IDX_W) - 1) / BUFFER_DEPTH;
    localparam int RED_STEPS = (RIDX_QMAX == 0) ? 0 : $clog2(RIDX_QMAX + 1);

    t_cfg  cfg;
    t_trig trig;
    logic  accept;
    logic  tick;

    logic [AW-1:0] widx;
    logic [AW:0]   fill;

    logic [IDX_W-1:0] ridx_red;
    logic [AW-1:0]    addr;
    logic [SW-1:0]    c1, c2;

    // memory stage
    logic               r_s1_valid;
    logic               r_s1_req;
    logic [AW-1:0]      r_s1_addr;
    logic               r_s1_filled;
    logic [SW-1:0]      r_s1_c1, r_s1_c2;
    logic [LAYER_W-1:0] r_s1_layer;
    t_trig              r_s1_trig;

    logic [2*SW-1:0]                 smp_rdata;
    logic [HISTORY_LAYERS*SW-1:0]    per_rdata;
    logic [HISTORY_LAYERS-1:0][SW-1:0] per_base, per_new;
    logic [HISTORY_LAYERS-1:0][SW-1:0] r_wb_row;
    logic                            r_wb_valid;
    logic [AW-1:0]                   r_wb_addr;
    logic                            per_we;
    logic                            fwd;
    logic [SW-1:0]                   rd_c1, rd_c2;
    logic                            layer_ok;

    t_result    s1_res;
    t_result    q_data;
    logic       q_pop;
    logic [1:0] q_count;

    etc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_stall = (3'(q_count) + 3'(r_s1_valid)) >= 3'(OUTQ_DEPTH);
    assign accept  = i_valid && !o_stall;
    assign tick    = accept && (i_req_type == REQ_SAMPLE);

    etc_trig #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_trig (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_tick        (tick),
        .i_trig_sample (i_trig_sample),
        .o_trig        (trig),
        .o_widx        (widx),
        .o_fill        (fill)
    );

    // read_index modulo the buffer depth, restoring subtraction
    always_comb begin
        ridx_red = i_read_index;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (32'(ridx_red) >= 32'(BUFFER_DEPTH << k)) begin
                ridx_red = ridx_red - IDX_W'(BUFFER_DEPTH << k);
            end
        end
    end

    assign addr = (i_req_type == REQ_READ) ? AW'(ridx_red) : widx;
    assign c1   = cfg.ch1_enable ? SW'(i_ch1_sample) : '0;
    assign c2   = cfg.ch2_enable ? SW'(i_ch2_sample) : '0;

    etc_ram #(
        .WIDTH (2 * SW),
        .DEPTH (BUFFER_DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (tick),
        .i_waddr (widx),
        .i_wdata ({c2, c1}),
        .i_raddr (addr),
        .o_rdata (smp_rdata)
    );

    etc_ram #(
        .WIDTH (HISTORY_LAYERS * SW),
        .DEPTH (BUFFER_DEPTH)
    ) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (r_s1_addr),
        .i_wdata (per_new),
        .i_raddr (addr),
        .o_rdata (per_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_wb_valid <= per_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req    <= i_req_type;
        r_s1_addr   <= addr;
        r_s1_filled <= ({1'b0, addr} < fill);
        r_s1_c1     <= c1;
        r_s1_c2     <= c2;
        r_s1_layer  <= i_read_layer;
        r_s1_trig   <= trig;
        r_wb_addr   <= r_s1_addr;
        r_wb_row    <= per_new;
    end

    // Persistence row: bypass of the previous write, zero where never written
    assign fwd      = r_wb_valid && (r_wb_addr == r_s1_addr);
    assign per_base = fwd ? r_wb_row : (r_s1_filled ? per_rdata : '0);
    assign per_we   = r_s1_valid && (r_s1_req == REQ_SAMPLE);

    always_comb begin
        per_new = per_base;
        if (r_s1_trig.push) begin
            for (int p = HISTORY_LAYERS - 1; p > 0; p--) begin
                per_new[p] = per_base[p-1];
            end
            per_new[0] = r_s1_c1;
        end
    end

    assign rd_c1    = r_s1_filled ? smp_rdata[SW-1:0] : '0;
    assign rd_c2    = r_s1_filled ? smp_rdata[2*SW-1:SW] : '0;
    assign layer_ok = 32'(r_s1_layer) < 32'(HISTORY_LAYERS);

    always_comb begin
        if (r_s1_req == REQ_READ) begin
            s1_res.triggered     = 1'b0;
            s1_res.capture_done  = 1'b0;
            s1_res.write_index   = '0;
            s1_res.ch1_value     = VAL_W'(rd_c1);
            s1_res.ch2_value     = VAL_W'(rd_c2);
            s1_res.persist_value = layer_ok ? VAL_W'(per_base[LW'(r_s1_layer)]) : '0;
            s1_res.armed_now     = r_s1_trig.armed_cur;
        end else begin
            s1_res.triggered     = r_s1_trig.fired;
            s1_res.capture_done  = r_s1_trig.done;
            s1_res.write_index   = IDX_W'(r_s1_addr);
            s1_res.ch1_value     = VAL_W'(r_s1_c1);
            s1_res.ch2_value     = VAL_W'(r_s1_c2);
            s1_res.persist_value = '0;
            s1_res.armed_now     = r_s1_trig.armed_now;
        end
    end

    assign q_pop = o_valid && !i_stall;

    etc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_res),
        .i_pop   (q_pop),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_triggered     = q_data.triggered;
    assign o_capture_done  = q_data.capture_done;
    assign o_write_index   = q_data.write_index;
    assign o_ch1_value     = q_data.ch1_value;
    assign o_ch2_value     = q_data.ch2_value;
    assign o_persist_value = q_data.persist_value;
    assign o_armed_now     = q_data.armed_now;

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (32'(q_count) < OUTQ_DEPTH) || q_pop)
        else $error("result queue overflow");

    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_req == REQ_SAMPLE && r_s1_trig.fired) |->
        !r_s1_trig.armed_now && !r_s1_trig.done)
        else $error("trigger fired without disarming");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(fill) <= BUFFER_DEPTH)
        else $error("fill level beyond buffer depth");
`endif

endmodule
`default_nettype wire
